@@ sv/kmde_pkg.sv @@
// Package for the key matrix debounce event block.
// Holds field widths, default sizes and the settle reset value; no dependencies.
package kmde_pkg;

    localparam int ROW_COUNT_DEF    = 10;
    localparam int COLUMN_COUNT_DEF = 6;

    localparam int ROW_W    = 4;
    localparam int LEVELS_W = 6;
    localparam int NOW_W    = 32;
    localparam int KCOL_W   = 3;
    localparam int SETTLE_W = 8;

    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 8'd5;

endpackage

@@ sv/key_matrix_debounce_events_top.sv @@
// Key matrix debouncer: scanned row samples in, settled press/release events out.
// Depends on kmde_pkg.
//
// Use: s_axis carries one scanned row per beat (row, active-low column bits,
// millisecond timestamp). A changed row restarts a global settle timer; once
// more than settle_ms milliseconds have passed, every key whose settled state
// differs is sent on m_axis as one beat, rows ascending then columns
// ascending, with tlast on the final beat of that run. cfg carries settle_ms
// and is always ready; write it only while the block is idle.
// Sequence: a sample that does not settle passes accept, row update and elapsed
// check; a settling sample then scans the ROW_COUNT x COLUMN_COUNT matrix (10 x 6
// by default) and ends with a flush step. The column/row sequencer examines one
// bit position per cycle, stalling on a changed key while the hold register is
// full and m_axis is stalled, and a single 32-bit subtract-and-compare does the
// elapsed test. s_axis_tready is low from accept until the sequencer is back to idle.
// Reset: every key up in both matrices, timer stopped, settle_ms = 5, no beat
// pending on m_axis. A stalled m_axis holds its beat; the scan then stops at
// a changed key while the hold register is full, until the output frees up.
module key_matrix_debounce_events_top
    import kmde_pkg::*;
#(
    parameter int ROW_COUNT    = ROW_COUNT_DEF,
    parameter int COLUMN_COUNT = COLUMN_COUNT_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // [3:0] row_index, [9:4] column_levels, [41:10] now_ms, [47:42] zero
    input  logic [47:0]         s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [3:0] key_row, [6:4] key_column, [7] zero
    output logic [7:0]          m_axis_tdata,
    // [0] is_release
    output logic [0:0]          m_axis_tuser,
    output logic                m_axis_tlast,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [SETTLE_W-1:0] cfg_data
);

    localparam int RW    = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int CW    = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
    localparam int LVL_W = (COLUMN_COUNT > LEVELS_W) ? COLUMN_COUNT : LEVELS_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_UPD   = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    typedef logic [COLUMN_COUNT-1:0] row_bits_t;

    logic [2:0]          state_reg, state_next;
    logic [SETTLE_W-1:0] settle_reg;
    logic [ROW_W-1:0]    row_reg;
    row_bits_t           lvl_reg;
    logic [NOW_W-1:0]    now_reg;
    logic [NOW_W-1:0]    start_reg;
    logic                busy_reg;
    row_bits_t           pending_reg [ROW_COUNT];
    row_bits_t           stable_reg  [ROW_COUNT];
    logic [RW-1:0]       scan_row_reg;
    logic [CW-1:0]       col_reg;

    logic                hold_valid_reg;
    logic [RW-1:0]       hold_row_reg;
    logic [CW-1:0]       hold_col_reg;
    logic                hold_rel_reg;

    logic                out_valid_reg;
    logic [ROW_W-1:0]    out_row_reg;
    logic [KCOL_W-1:0]   out_col_reg;
    logic                out_rel_reg;
    logic                out_last_reg;

    logic [LVL_W-1:0]    lvl_ext;
    logic                accept;
    logic                row_ok;
    logic [RW-1:0]       rd_row;
    row_bits_t           pend_rd;
    row_bits_t           stab_rd;
    logic                upd_hit;
    logic [NOW_W-1:0]    elapsed;
    logic                settled;
    logic                out_free;
    logic                diff_bit;
    logic                scan_adv;
    logic                last_col;
    logic                last_row;
    logic                push_scan;
    logic                push_flush;

    assign lvl_ext = LVL_W'(s_axis_tdata[9:4]);
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;

    assign row_ok  = ({1'b0, row_reg} < (ROW_W + 1)'(ROW_COUNT));
    assign rd_row  = (state_reg == S_UPD) ? row_reg[RW-1:0] : scan_row_reg;
    assign pend_rd = pending_reg[rd_row];
    assign stab_rd = stable_reg[rd_row];
    assign upd_hit = row_ok && (lvl_reg != pend_rd);

    assign elapsed = now_reg - start_reg;
    assign settled = busy_reg && (elapsed > NOW_W'(settle_reg));

    assign out_free = !out_valid_reg || m_axis_tready;
    assign diff_bit = pend_rd[col_reg] ^ stab_rd[col_reg];
    assign scan_adv = !(diff_bit && hold_valid_reg && !out_free);
    assign last_col = (col_reg == CW'(COLUMN_COUNT - 1));
    assign last_row = (scan_row_reg == RW'(ROW_COUNT - 1));

    assign push_scan  = (state_reg == S_SCAN) && diff_bit && hold_valid_reg && out_free;
    assign push_flush = (state_reg == S_FLUSH) && hold_valid_reg && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_UPD;
            end
            S_UPD:
                state_next = S_CHK;
            S_CHK:
                state_next = settled ? S_SCAN : S_IDLE;
            S_SCAN:
            begin
                if (scan_adv && last_col && last_row)
                    state_next = S_FLUSH;
            end
            S_FLUSH:
            begin
                if (!hold_valid_reg || out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            settle_reg     <= SETTLE_RESET;
            busy_reg       <= 1'b0;
            start_reg      <= '0;
            scan_row_reg   <= '0;
            col_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int r = 0; r < ROW_COUNT; r++)
            begin
                pending_reg[r] <= '1;
                stable_reg[r]  <= '1;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
                settle_reg <= cfg_data;

            // update step: on a changed row, update the pending row and restart the timer
            if (state_reg == S_UPD && upd_hit)
            begin
                pending_reg[row_reg[RW-1:0]] <= lvl_reg;
                busy_reg  <= 1'b1;
                start_reg <= now_reg;
            end

            if (state_reg == S_CHK && settled)
            begin
                busy_reg     <= 1'b0;
                scan_row_reg <= '0;
                col_reg      <= '0;
            end

            // advance one bit position; keep the newest change in hold
            if (state_reg == S_SCAN && scan_adv)
            begin
                if (diff_bit)
                begin
                    hold_valid_reg <= 1'b1;
                    hold_row_reg   <= scan_row_reg;
                    hold_col_reg   <= col_reg;
                    hold_rel_reg   <= pend_rd[col_reg];
                end
                if (last_col)
                begin
                    stable_reg[scan_row_reg] <= pend_rd;
                    col_reg <= '0;
                    if (!last_row)
                        scan_row_reg <= scan_row_reg + 1'b1;
                end
                else
                    col_reg <= col_reg + 1'b1;
            end

            if (push_flush)
                hold_valid_reg <= 1'b0;

            if (push_scan || push_flush)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg <= s_axis_tdata[3:0];
            lvl_reg <= lvl_ext[COLUMN_COUNT-1:0];
            now_reg <= s_axis_tdata[41:10];
        end
        if (push_scan || push_flush)
        begin
            out_row_reg  <= ROW_W'(hold_row_reg);
            out_col_reg  <= KCOL_W'(hold_col_reg);
            out_rel_reg  <= hold_rel_reg;
            out_last_reg <= push_flush;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_col_reg, out_row_reg};
    assign m_axis_tuser  = out_rel_reg;
    assign m_axis_tlast  = out_last_reg;

    a_ready_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !hold_valid_reg)
        else $error("input ready while an event is still held");

    a_scan_timer_off: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> !busy_reg)
        else $error("settle timer running during scan");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg) == S_SCAN || $past(state_reg) == S_FLUSH)
        else $error("output beat raised outside scan or flush");

endmodule
